### hdl/prjr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prjr_pkg
// Types, constants and helpers shared by the pose re-origin unit and its
// CORDIC engine.
// ----------------------------------------------------------------------------
package prjr_pkg;

	localparam int unsigned QUAT_FRAC_BITS_DEF = 14;
	localparam int unsigned CORDIC_ITERS_DEF   = 16;

	localparam int unsigned ACC_W       = 52;
	localparam int unsigned CORD_W      = 40;
	localparam int unsigned STEP_W      = 5;
	localparam int unsigned RES_N       = 9;
	localparam int unsigned SQRT_STEPS  = 25;
	localparam int unsigned SQRT_W      = 49;
	localparam int unsigned ROOT_W      = 25;

	localparam logic signed [CORD_W-1:0] GAIN_Q30 = 40'sd652032875;

	localparam logic signed [ACC_W-1:0] S16_MAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] S16_MIN = {{(ACC_W-15){1'b1}}, 15'd0};
	localparam logic signed [ACC_W-1:0] S32_MAX = ACC_W'(2147483647);
	localparam logic signed [ACC_W-1:0] S32_MIN = {{(ACC_W-31){1'b1}}, 31'd0};

	localparam logic REG_JUMP_THRESHOLD = 1'b0;
	localparam logic REG_CALIB_WINDOW   = 1'b1;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
	} pose_in_t;

	typedef struct packed {
		logic signed [31:0] rel_x;
		logic signed [31:0] rel_y;
		logic signed [15:0] rel_qx;
		logic signed [15:0] rel_qy;
		logic signed [15:0] rel_qz;
		logic signed [15:0] rel_qw;
		logic               jump_warning;
		logic               recalibrated;
	} pose_out_t;

	typedef enum logic [3:0] {
		OP_QX, OP_QY, OP_QZ, OP_QW,
		OP_OX, OP_OY, OP_OZ, OP_OW,
		OP_DX, OP_DY, OP_CS, OP_SN
	} opnd_t;

	typedef enum logic [3:0] {
		RES_N2, RES_A, RES_B, RES_RX, RES_RY,
		RES_QX, RES_QY, RES_QZ, RES_QW
	} res_t;

	typedef struct packed {
		opnd_t a_sel;
		opnd_t b_sel;
		logic  neg;
		logic  last;
		res_t  dest;
	} mac_op_t;

	typedef struct packed {
		logic               done;
		logic signed [15:0] cos_v;
		logic signed [15:0] sin_v;
	} cord_res_t;

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_RUN  = 3'b010,
		C_FIN  = 3'b100
	} cord_state_t;

	function automatic mac_op_t mac_op(input logic [STEP_W-1:0] step);
		mac_op_t op;
		op = '{OP_QX, OP_QX, 1'b0, 1'b0, RES_N2};
		unique case (step)
			5'd0:  op = '{OP_QX, OP_QX, 1'b0, 1'b0, RES_N2};
			5'd1:  op = '{OP_QY, OP_QY, 1'b0, 1'b0, RES_N2};
			5'd2:  op = '{OP_QZ, OP_QZ, 1'b0, 1'b0, RES_N2};
			5'd3:  op = '{OP_QW, OP_QW, 1'b0, 1'b1, RES_N2};
			5'd4:  op = '{OP_OW, OP_OW, 1'b0, 1'b0, RES_A};
			5'd5:  op = '{OP_OX, OP_OX, 1'b0, 1'b0, RES_A};
			5'd6:  op = '{OP_OY, OP_OY, 1'b1, 1'b0, RES_A};
			5'd7:  op = '{OP_OZ, OP_OZ, 1'b1, 1'b1, RES_A};
			5'd8:  op = '{OP_OX, OP_OY, 1'b0, 1'b0, RES_B};
			5'd9:  op = '{OP_OW, OP_OZ, 1'b0, 1'b1, RES_B};
			5'd10: op = '{OP_DX, OP_CS, 1'b0, 1'b0, RES_RX};
			5'd11: op = '{OP_DY, OP_SN, 1'b0, 1'b1, RES_RX};
			5'd12: op = '{OP_DY, OP_CS, 1'b0, 1'b0, RES_RY};
			5'd13: op = '{OP_DX, OP_SN, 1'b1, 1'b1, RES_RY};
			5'd14: op = '{OP_OW, OP_QX, 1'b0, 1'b0, RES_QX};
			5'd15: op = '{OP_OX, OP_QW, 1'b1, 1'b0, RES_QX};
			5'd16: op = '{OP_OY, OP_QZ, 1'b1, 1'b0, RES_QX};
			5'd17: op = '{OP_OZ, OP_QY, 1'b0, 1'b1, RES_QX};
			5'd18: op = '{OP_OW, OP_QY, 1'b0, 1'b0, RES_QY};
			5'd19: op = '{OP_OX, OP_QZ, 1'b0, 1'b0, RES_QY};
			5'd20: op = '{OP_OY, OP_QW, 1'b1, 1'b0, RES_QY};
			5'd21: op = '{OP_OZ, OP_QX, 1'b1, 1'b1, RES_QY};
			5'd22: op = '{OP_OW, OP_QZ, 1'b0, 1'b0, RES_QZ};
			5'd23: op = '{OP_OX, OP_QY, 1'b1, 1'b0, RES_QZ};
			5'd24: op = '{OP_OY, OP_QX, 1'b0, 1'b0, RES_QZ};
			5'd25: op = '{OP_OZ, OP_QW, 1'b1, 1'b1, RES_QZ};
			5'd26: op = '{OP_OW, OP_QW, 1'b0, 1'b0, RES_QW};
			5'd27: op = '{OP_OX, OP_QX, 1'b0, 1'b0, RES_QW};
			5'd28: op = '{OP_OY, OP_QY, 1'b0, 1'b0, RES_QW};
			5'd29: op = '{OP_OZ, OP_QZ, 1'b0, 1'b1, RES_QW};
			default: op = '{OP_QX, OP_QX, 1'b0, 1'b0, RES_N2};
		endcase
		return op;
	endfunction

	function automatic logic signed [ACC_W-1:0] round_half_away(
		input logic signed [ACC_W-1:0] v,
		input int unsigned             sh
	);
		logic [ACC_W-1:0] mag;
		logic [ACC_W-1:0] r;
		mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
		r   = (mag + (ACC_W'(1) << (sh - 1))) >> sh;
		return v[ACC_W-1] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
		if (v > S16_MAX)
			return 16'sh7fff;
		else if (v < S16_MIN)
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		if (v > S32_MAX)
			return 32'sh7fffffff;
		else if (v < S32_MIN)
			return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage

### hdl/prjr_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prjr_cordic
// Iterative CORDIC: vectors (a, b) toward the x axis and applies the inverse
// micro-rotations to a gain-compensated unit vector to give cos and sin.
// ----------------------------------------------------------------------------
module prjr_cordic #(
	parameter int unsigned ITERS = prjr_pkg::CORDIC_ITERS_DEF,
	parameter int unsigned QFB   = prjr_pkg::QUAT_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [prjr_pkg::CORD_W-1:0] vec_a,
	input  logic signed [prjr_pkg::CORD_W-1:0] vec_b,
	output prjr_pkg::cord_res_t                 res
);
	import prjr_pkg::*;

	localparam int unsigned IT_W = $clog2(ITERS);

	cord_state_t              state_q;
	logic [IT_W-1:0]          it_q;
	logic signed [CORD_W-1:0] a_q, b_q, c_q, d_q;
	logic signed [CORD_W-1:0] sa, sb, sc, sd;
	logic                     dir;
	logic                     done_q;
	logic signed [15:0]       cos_q, sin_q;

	assign sa  = a_q >>> it_q;
	assign sb  = b_q >>> it_q;
	assign sc  = c_q >>> it_q;
	assign sd  = d_q >>> it_q;
	assign dir = !b_q[CORD_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			it_q    <= '0;
			a_q     <= '0;
			b_q     <= '0;
			c_q     <= '0;
			d_q     <= '0;
			done_q  <= 1'b0;
			cos_q   <= '0;
			sin_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						it_q <= '0;
						if (vec_a[CORD_W-1]) begin
							c_q <= '0;
							if (!vec_b[CORD_W-1]) begin
								a_q <= vec_b;
								b_q <= -vec_a;
								d_q <= GAIN_Q30;
							end else begin
								a_q <= -vec_b;
								b_q <= vec_a;
								d_q <= -GAIN_Q30;
							end
						end else begin
							a_q <= vec_a;
							b_q <= vec_b;
							c_q <= GAIN_Q30;
							d_q <= '0;
						end
						state_q <= C_RUN;
					end
				end
				C_RUN: begin
					if (dir) begin
						a_q <= a_q + sb;
						b_q <= b_q - sa;
						c_q <= c_q - sd;
						d_q <= d_q + sc;
					end else begin
						a_q <= a_q - sb;
						b_q <= b_q + sa;
						c_q <= c_q + sd;
						d_q <= d_q - sc;
					end
					it_q <= it_q + 1'b1;
					if (it_q == IT_W'(ITERS - 1))
						state_q <= C_FIN;
				end
				C_FIN: begin
					cos_q   <= sat16(round_half_away(ACC_W'(c_q), 30 - QFB));
					sin_q   <= sat16(round_half_away(ACC_W'(d_q), 30 - QFB));
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign res = '{done_q, cos_q, sin_q};

endmodule

### hdl/pose_reorigin_with_jump_recalibration_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_reorigin_with_jump_recalibration_unit
// Detects position jumps, re-latches origin and yaw on recalibration, and
// returns the pose relative to the origin. One shared multiply-accumulate
// unit, a bit-serial square root, a restoring divider and a CORDIC engine
// run under one sequencer; one item is in flight at a time.
// A tracking item runs 20 MAC steps on the shared multiplier; a recalibrating
//   item adds the norm and yaw MAC steps and, where needed, the square root,
//   four divisions and the CORDIC iterations.
// The next item is taken in once the current one has moved to the output
//   register; a result waiting in the output register does not block the
//   next transfer in.
// Reset: origin, previous position, orientation and counters clear to zero,
//   uncalibrated; jump_threshold = 1.0, calib_window = 10.
// ----------------------------------------------------------------------------
module pose_reorigin_with_jump_recalibration_unit #(
	parameter int unsigned QUAT_FRAC_BITS = prjr_pkg::QUAT_FRAC_BITS_DEF,
	parameter int unsigned CORDIC_ITERS   = prjr_pkg::CORDIC_ITERS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  prjr_pkg::pose_in_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output prjr_pkg::pose_out_t out_item,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import prjr_pkg::*;

	localparam int unsigned QB     = QUAT_FRAC_BITS + 3;
	localparam int unsigned DIV_W  = ROOT_W + QB;
	localparam int unsigned QCNT_W = $clog2(QB);
	localparam int unsigned SCNT_W = $clog2(SQRT_STEPS);

	localparam logic [STEP_W-1:0] STEP_NORM_END  = 5'd3;
	localparam logic [STEP_W-1:0] STEP_YAW_BEGIN = 5'd4;
	localparam logic [STEP_W-1:0] STEP_YAW_END   = 5'd9;
	localparam logic [STEP_W-1:0] STEP_OUT_BEGIN = 5'd10;
	localparam logic [STEP_W-1:0] STEP_OUT_END   = 5'd29;
	localparam logic [8:0]        COUNT_MAX      = 9'd256;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_JUMP  = 9'b000000010,
		S_MAC   = 9'b000000100,
		S_DRAIN = 9'b000001000,
		S_WAIT  = 9'b000010000,
		S_SQRT  = 9'b000100000,
		S_DLOAD = 9'b001000000,
		S_DIV   = 9'b010000000,
		S_CORD  = 9'b100000000
	} state_t;

	// output stage is S_WAIT after the last output step
	state_t                  state_q;
	pose_in_t                item_q;
	logic [STEP_W-1:0]       step_q;
	logic [30:0]             thr_q;
	logic [7:0]              win_q;
	logic signed [31:0]      orig_x_q, orig_y_q, prev_x_q, prev_y_q;
	logic                    calib_q;
	logic [8:0]              count_q;
	logic                    warn_q, recal_q;
	logic signed [32:0]      dx_q, dy_q;
	logic signed [15:0]      oq_q [4];
	logic signed [15:0]      cs_q, sn_q;

	logic signed [48:0]      prod_s1;
	logic                    vld_s1, neg_s1, last_s1;
	res_t                    dest_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] res_q [RES_N];

	logic [SQRT_W-1:0]       sq_n_q, sq_bit_q;
	logic [SQRT_W:0]         sq_r_q;
	logic [SCNT_W-1:0]       sq_cnt_q;
	logic [ROOT_W-1:0]       s_q;
	logic [1:0]              div_idx_q;
	logic [QCNT_W-1:0]       div_cnt_q;
	logic [DIV_W-1:0]        rem_q, dvs_q;
	logic [QB-1:0]           quo_q;

	logic                    out_valid_q;
	pose_out_t               out_item_q;
	logic                    out_load;

	mac_op_t                 op;
	logic signed [32:0]      mul_a;
	logic signed [15:0]      mul_b;
	logic signed [48:0]      prod;
	logic signed [ACC_W-1:0] prod_ext, mac_sum;

	logic signed [32:0]      jdx, jdy;
	logic [32:0]             jax, jay;
	logic                    jump_c, in_window, recal_c;

	logic [SQRT_W:0]         sq_t, sq_r_next;
	logic                    sq_ge;
	logic signed [15:0]      qin [4];
	logic [15:0]             qmag;
	logic [DIV_W-1:0]        div_num;
	logic                    div_ge;
	logic [QB-1:0]           quo_next;
	logic [ACC_W-1:0]        quo_ext;

	logic                    yaw_zero, cord_start;
	cord_res_t               cord_res;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign pready    = 1'b1;
	assign out_load  = (state_q == S_WAIT) && (step_q == STEP_OUT_END) &&
		(!out_valid_q || !out_stall);

	always_comb begin
		unique case (paddr[2])
			REG_JUMP_THRESHOLD: prdata = {1'b0, thr_q};
			REG_CALIB_WINDOW:   prdata = {24'd0, win_q};
			default:            prdata = '0;
		endcase
	end

	// Shared multiplier
	assign op = mac_op(step_q);

	always_comb begin
		unique case (op.a_sel)
			OP_QX:   mul_a = 33'(item_q.quat_x);
			OP_QY:   mul_a = 33'(item_q.quat_y);
			OP_QZ:   mul_a = 33'(item_q.quat_z);
			OP_QW:   mul_a = 33'(item_q.quat_w);
			OP_OX:   mul_a = 33'(oq_q[0]);
			OP_OY:   mul_a = 33'(oq_q[1]);
			OP_OZ:   mul_a = 33'(oq_q[2]);
			OP_OW:   mul_a = 33'(oq_q[3]);
			OP_DX:   mul_a = dx_q;
			OP_DY:   mul_a = dy_q;
			default: mul_a = '0;
		endcase
		unique case (op.b_sel)
			OP_QX:   mul_b = item_q.quat_x;
			OP_QY:   mul_b = item_q.quat_y;
			OP_QZ:   mul_b = item_q.quat_z;
			OP_QW:   mul_b = item_q.quat_w;
			OP_OX:   mul_b = oq_q[0];
			OP_OY:   mul_b = oq_q[1];
			OP_OZ:   mul_b = oq_q[2];
			OP_OW:   mul_b = oq_q[3];
			OP_CS:   mul_b = cs_q;
			OP_SN:   mul_b = sn_q;
			default: mul_b = '0;
		endcase
	end

	assign prod     = 49'(mul_a) * 49'(mul_b);
	assign prod_ext = ACC_W'(prod_s1);
	assign mac_sum  = acc_q + (neg_s1 ? -prod_ext : prod_ext);

	// Jump test
	assign jdx       = 33'(item_q.pos_x) - 33'(prev_x_q);
	assign jdy       = 33'(item_q.pos_y) - 33'(prev_y_q);
	assign jax       = jdx[32] ? 33'(-jdx) : 33'(jdx);
	assign jay       = jdy[32] ? 33'(-jdy) : 33'(jdy);
	assign jump_c    = (jax > 33'(thr_q)) || (jay > 33'(thr_q));
	assign in_window = (count_q <= {1'b0, win_q});
	assign recal_c   = !calib_q || (jump_c && in_window);

	// Square root step
	assign sq_t      = sq_r_q + (SQRT_W + 1)'(sq_bit_q);
	assign sq_ge     = ((SQRT_W + 1)'(sq_n_q) >= sq_t);
	assign sq_r_next = sq_ge ? ((sq_r_q >> 1) + (SQRT_W + 1)'(sq_bit_q)) : (sq_r_q >> 1);

	// Divide step
	assign qin[0]   = item_q.quat_x;
	assign qin[1]   = item_q.quat_y;
	assign qin[2]   = item_q.quat_z;
	assign qin[3]   = item_q.quat_w;
	assign qmag     = qin[div_idx_q][15] ? 16'(-17'(qin[div_idx_q])) : 16'(qin[div_idx_q]);
	assign div_num  = (DIV_W'(qmag) << (QUAT_FRAC_BITS + 8)) + DIV_W'(s_q >> 1);
	assign div_ge   = (rem_q >= dvs_q);
	assign quo_next = {quo_q[QB-2:0], div_ge};
	assign quo_ext  = ACC_W'(quo_next);

	assign yaw_zero   = (res_q[RES_A] == '0) && (res_q[RES_B] == '0);
	assign cord_start = (state_q == S_WAIT) && (step_q == STEP_YAW_END) && !yaw_zero;

	prjr_cordic #(
		.ITERS (CORDIC_ITERS),
		.QFB   (QUAT_FRAC_BITS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.vec_a  (res_q[RES_A][CORD_W-1:0]),
		.vec_b  ({res_q[RES_B][CORD_W-2:0], 1'b0}),
		.res    (cord_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			item_q      <= '0;
			step_q      <= '0;
			thr_q       <= 31'd65536;
			win_q       <= 8'd10;
			orig_x_q    <= '0;
			orig_y_q    <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			calib_q     <= 1'b0;
			count_q     <= '0;
			warn_q      <= 1'b0;
			recal_q     <= 1'b0;
			dx_q        <= '0;
			dy_q        <= '0;
			for (int i = 0; i < 4; i++)
				oq_q[i] <= '0;
			cs_q        <= '0;
			sn_q        <= '0;
			prod_s1     <= '0;
			vld_s1      <= 1'b0;
			neg_s1      <= 1'b0;
			last_s1     <= 1'b0;
			dest_s1     <= RES_N2;
			acc_q       <= '0;
			for (int i = 0; i < RES_N; i++)
				res_q[i] <= '0;
			sq_n_q      <= '0;
			sq_bit_q    <= '0;
			sq_r_q      <= '0;
			sq_cnt_q    <= '0;
			s_q         <= '0;
			div_idx_q   <= '0;
			div_cnt_q   <= '0;
			rem_q       <= '0;
			dvs_q       <= '0;
			quo_q       <= '0;
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
		end else begin
			if (psel && penable && pwrite) begin
				unique case (paddr[2])
					REG_JUMP_THRESHOLD: thr_q <= pwdata[30:0];
					REG_CALIB_WINDOW:   win_q <= pwdata[7:0];
					default:            thr_q <= thr_q;
				endcase
			end

			// accumulate stage of the shared multiplier
			vld_s1  <= (state_q == S_MAC);
			prod_s1 <= prod;
			neg_s1  <= op.neg;
			last_s1 <= op.last;
			dest_s1 <= op.dest;
			if (vld_s1) begin
				if (last_s1) begin
					acc_q           <= '0;
					res_q[dest_s1]  <= mac_sum;
				end else begin
					acc_q <= mac_sum;
				end
			end

			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_item;
						state_q <= S_JUMP;
					end
				end
				S_JUMP: begin
					warn_q   <= jump_c && !in_window;
					recal_q  <= recal_c;
					calib_q  <= 1'b1;
					prev_x_q <= item_q.pos_x;
					prev_y_q <= item_q.pos_y;
					if (count_q != COUNT_MAX)
						count_q <= count_q + 1'b1;
					if (recal_c) begin
						orig_x_q <= item_q.pos_x;
						orig_y_q <= item_q.pos_y;
						dx_q     <= '0;
						dy_q     <= '0;
						step_q   <= '0;
					end else begin
						dx_q   <= 33'(item_q.pos_x) - 33'(orig_x_q);
						dy_q   <= 33'(item_q.pos_y) - 33'(orig_y_q);
						step_q <= STEP_OUT_BEGIN;
					end
					state_q <= S_MAC;
				end
				S_MAC: begin
					if (step_q == STEP_NORM_END || step_q == STEP_YAW_END ||
						step_q == STEP_OUT_END)
						state_q <= S_DRAIN;
					else
						step_q <= step_q + 1'b1;
				end
				S_DRAIN: state_q <= S_WAIT;
				S_WAIT: begin
					priority if (step_q == STEP_NORM_END) begin
						if (res_q[RES_N2] == '0) begin
							oq_q[0] <= '0;
							oq_q[1] <= '0;
							oq_q[2] <= '0;
							oq_q[3] <= 16'(1 << QUAT_FRAC_BITS);
							step_q  <= STEP_YAW_BEGIN;
							state_q <= S_MAC;
						end else begin
							sq_n_q   <= SQRT_W'(res_q[RES_N2][32:0]) << 16;
							sq_r_q   <= '0;
							sq_bit_q <= SQRT_W'(1) << (SQRT_W - 1);
							sq_cnt_q <= '0;
							state_q  <= S_SQRT;
						end
					end else if (step_q == STEP_YAW_END) begin
						if (yaw_zero) begin
							cs_q    <= 16'(1 << QUAT_FRAC_BITS);
							sn_q    <= '0;
							step_q  <= STEP_OUT_BEGIN;
							state_q <= S_MAC;
						end else begin
							state_q <= S_CORD;
						end
					end else begin
						// hold a finished item until the output register frees
						if (out_load) begin
							out_item_q.rel_x        <= sat32(round_half_away(res_q[RES_RX], QUAT_FRAC_BITS));
							out_item_q.rel_y        <= sat32(round_half_away(res_q[RES_RY], QUAT_FRAC_BITS));
							out_item_q.rel_qx       <= sat16(round_half_away(res_q[RES_QX], QUAT_FRAC_BITS));
							out_item_q.rel_qy       <= sat16(round_half_away(res_q[RES_QY], QUAT_FRAC_BITS));
							out_item_q.rel_qz       <= sat16(round_half_away(res_q[RES_QZ], QUAT_FRAC_BITS));
							out_item_q.rel_qw       <= sat16(round_half_away(res_q[RES_QW], QUAT_FRAC_BITS));
							out_item_q.jump_warning <= warn_q;
							out_item_q.recalibrated <= recal_q;
							state_q                 <= S_IDLE;
						end
					end
				end
				S_SQRT: begin
					if (sq_ge)
						sq_n_q <= sq_n_q - SQRT_W'(sq_t);
					sq_r_q   <= sq_r_next;
					sq_bit_q <= sq_bit_q >> 2;
					sq_cnt_q <= sq_cnt_q + 1'b1;
					if (sq_cnt_q == SCNT_W'(SQRT_STEPS - 1)) begin
						s_q       <= sq_r_next[ROOT_W-1:0];
						div_idx_q <= '0;
						state_q   <= S_DLOAD;
					end
				end
				S_DLOAD: begin
					rem_q     <= div_num;
					dvs_q     <= DIV_W'(s_q) << (QB - 1);
					quo_q     <= '0;
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					if (div_ge)
						rem_q <= rem_q - dvs_q;
					dvs_q     <= dvs_q >> 1;
					quo_q     <= quo_next;
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == QCNT_W'(QB - 1)) begin
						oq_q[div_idx_q] <= sat16($signed(qin[div_idx_q][15] ? -quo_ext : quo_ext));
						if (div_idx_q == 2'd3) begin
							step_q  <= STEP_YAW_BEGIN;
							state_q <= S_MAC;
						end else begin
							div_idx_q <= div_idx_q + 1'b1;
							state_q   <= S_DLOAD;
						end
					end
				end
				S_CORD: begin
					if (cord_res.done) begin
						cs_q    <= cord_res.cos_v;
						sn_q    <= cord_res.sin_v;
						step_q  <= STEP_OUT_BEGIN;
						state_q <= S_MAC;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pose samples into the re-origin unit with random gaps and output
// stalls, predicts every result (jump detection, origin latch, normalization,
// CORDIC yaw, rotated offset, relative quaternion) and compares it field by
// field. Both registers are written over several phases, extremes included.
// ----------------------------------------------------------------------------
module testbench;
	import prjr_pkg::*;

	localparam int QFB = 14;
	localparam int ITERS = 16;
	localparam longint GAIN = 652032875;
	localparam int WATCHDOG_LIMIT = 20000;

	class pose_scoreboard;
		longint thresh, window;
		longint org_x, org_y, prev_x, prev_y;
		longint org_q[4];
		longint org_cs[2];
		bit calibrated;
		int count;
		pose_out_t pending[$];
		int errors;

		function void clear();
			thresh = 65536;
			window = 10;
			org_x = 0; org_y = 0; prev_x = 0; prev_y = 0;
			org_q = '{0, 0, 0, 0};
			org_cs = '{0, 0};
			calibrated = 0;
			count = 0;
			errors = 0;
		endfunction

		function longint shr_floor(longint v, int s);
			return v >>> s;
		endfunction

		function longint round_away(longint v, int s);
			longint h;
			h = longint'(1) << (s - 1);
			if (v >= 0)
				return (v + h) >>> s;
			return -((-v + h) >>> s);
		endfunction

		function longint clip(longint v, int w);
			longint hi, lo;
			hi = (longint'(1) << (w - 1)) - 1;
			lo = -hi - 1;
			return v > hi ? hi : (v < lo ? lo : v);
		endfunction

		function longint int_sqrt(longint unsigned n);
			longint unsigned r, b;
			r = 0;
			b = longint'(1) << 62;
			while (b > n)
				b >>= 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function void latch_heading(longint q[4]);
			longint unsigned n2, s, mag;
			longint a, b, c, d, t, da, db, v;
			int pre;
			bit dir[ITERS];
			n2 = 0;
			pre = 0;
			for (int i = 0; i < 4; i++)
				n2 += q[i] * q[i];
			if (n2 == 0) begin
				org_q = '{0, 0, 0, longint'(1) << QFB};
			end else begin
				s = int_sqrt(n2 << 16);
				for (int i = 0; i < 4; i++) begin
					mag = q[i] < 0 ? -q[i] : q[i];
					v = ((mag << (QFB + 8)) + s / 2) / s;
					org_q[i] = clip(q[i] < 0 ? -v : v, 16);
				end
			end
			a = org_q[3] * org_q[3] + org_q[0] * org_q[0] - org_q[1] * org_q[1]
				- org_q[2] * org_q[2];
			b = 2 * (org_q[0] * org_q[1] + org_q[3] * org_q[2]);
			if (a == 0 && b == 0) begin
				org_cs = '{longint'(1) << QFB, 0};
				return;
			end
			if (a < 0) begin
				if (b >= 0) begin
					t = a; a = b; b = -t; pre = 1;
				end else begin
					t = a; a = -b; b = t; pre = -1;
				end
			end
			for (int i = 0; i < ITERS; i++) begin
				da = shr_floor(b, i);
				db = shr_floor(a, i);
				dir[i] = b >= 0;
				if (dir[i]) begin
					a += da; b -= db;
				end else begin
					a -= da; b += db;
				end
			end
			c = GAIN;
			d = 0;
			if (pre == 1) begin
				t = c; c = -d; d = t;
			end else if (pre == -1) begin
				t = c; c = d; d = -t;
			end
			for (int i = 0; i < ITERS; i++) begin
				da = shr_floor(d, i);
				db = shr_floor(c, i);
				if (dir[i]) begin
					c -= da; d += db;
				end else begin
					c += da; d -= db;
				end
			end
			org_cs[0] = clip(round_away(c, 30 - QFB), 16);
			org_cs[1] = clip(round_away(d, 30 - QFB), 16);
		endfunction

		function void note_pose(pose_in_t p);
			longint px, py, dx, dy, ox, oy, oz, ow;
			longint q[4];
			longint r[4];
			bit warn, recal;
			pose_out_t e;
			px = p.pos_x;
			py = p.pos_y;
			q = '{p.quat_x, p.quat_y, p.quat_z, p.quat_w};
			warn = 0;
			recal = 0;
			dx = px - prev_x;
			dy = py - prev_y;
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			if (dx > thresh || dy > thresh) begin
				if (count <= window)
					calibrated = 0;
				else
					warn = 1;
			end
			if (!calibrated) begin
				org_x = px;
				org_y = py;
				latch_heading(q);
				calibrated = 1;
				recal = 1;
			end
			dx = px - org_x;
			dy = py - org_y;
			e.rel_x = 32'(clip(round_away(dx * org_cs[0] + dy * org_cs[1], QFB), 32));
			e.rel_y = 32'(clip(round_away(dy * org_cs[0] - dx * org_cs[1], QFB), 32));
			ox = -org_q[0]; oy = -org_q[1]; oz = -org_q[2]; ow = org_q[3];
			r[0] = ow * q[0] + ox * q[3] + oy * q[2] - oz * q[1];
			r[1] = ow * q[1] - ox * q[2] + oy * q[3] + oz * q[0];
			r[2] = ow * q[2] + ox * q[1] - oy * q[0] + oz * q[3];
			r[3] = ow * q[3] - ox * q[0] - oy * q[1] - oz * q[2];
			e.rel_qx = 16'(clip(round_away(r[0], QFB), 16));
			e.rel_qy = 16'(clip(round_away(r[1], QFB), 16));
			e.rel_qz = 16'(clip(round_away(r[2], QFB), 16));
			e.rel_qw = 16'(clip(round_away(r[3], QFB), 16));
			e.jump_warning = warn;
			e.recalibrated = recal;
			pending.push_back(e);
			if (count < 256)
				count++;
			prev_x = px;
			prev_y = py;
		endfunction

		function void check_result(pose_out_t got);
			pose_out_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.rel_x !== e.rel_x)
				$display("%0t: rel_x exp %0d got %0d", $time, e.rel_x, got.rel_x);
			if (got.rel_y !== e.rel_y)
				$display("%0t: rel_y exp %0d got %0d", $time, e.rel_y, got.rel_y);
			if (got.rel_qx !== e.rel_qx)
				$display("%0t: rel_qx exp %0d got %0d", $time, e.rel_qx, got.rel_qx);
			if (got.rel_qy !== e.rel_qy)
				$display("%0t: rel_qy exp %0d got %0d", $time, e.rel_qy, got.rel_qy);
			if (got.rel_qz !== e.rel_qz)
				$display("%0t: rel_qz exp %0d got %0d", $time, e.rel_qz, got.rel_qz);
			if (got.rel_qw !== e.rel_qw)
				$display("%0t: rel_qw exp %0d got %0d", $time, e.rel_qw, got.rel_qw);
			if (got.jump_warning !== e.jump_warning)
				$display("%0t: jump_warning exp %0b got %0b", $time, e.jump_warning,
					got.jump_warning);
			if (got.recalibrated !== e.recalibrated)
				$display("%0t: recalibrated exp %0b got %0b", $time, e.recalibrated,
					got.recalibrated);
			if (got !== e)
				errors++;
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	pose_in_t in_item = '0;
	logic out_valid;
	logic out_stall = 0;
	pose_out_t out_item;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	pose_scoreboard board = new();
	int idle_cycles = 0;
	bit rx_busy = 1;

	always #5 clk = ~clk;

	pose_reorigin_with_jump_recalibration_unit u_dut (
		.clk, .arst_n, .in_valid, .in_stall, .in_item, .out_valid, .out_stall,
		.out_item, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(out_item);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// receiver: random stall stretches, one phase with none
	initial begin
		int n;
		@(posedge clk);
		while (1) begin
			n = rx_busy ? $urandom_range(0, 17) : 0;
			if (n > 0) begin
				out_stall <= 1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic write_reg(logic [2:0] addr, logic [31:0] value);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= addr; pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (addr == 3'(4 * REG_JUMP_THRESHOLD))
			board.thresh = value & 32'h7fffffff;
		else
			board.window = value & 8'hff;
		@(posedge clk);
	endtask

	task automatic send_pose(pose_in_t p, int gap);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_item <= p;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_pose(p);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_q();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(0, 32767)) - 16384);
			default: return 16'($signed($urandom_range(0, 16384)) - 8192);
		endcase
	endfunction

	function automatic pose_in_t near_pose(pose_in_t last, int span);
		pose_in_t p;
		p = last;
		p.pos_x = last.pos_x + $signed($urandom_range(0, 2 * span)) - span;
		p.pos_y = last.pos_y + $signed($urandom_range(0, 2 * span)) - span;
		p.quat_x = rand_q(); p.quat_y = rand_q();
		p.quat_z = rand_q(); p.quat_w = rand_q();
		return p;
	endfunction

	initial begin
		pose_in_t p, last;
		int gap_max;
		board.clear();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// edge values of every field, zero quaternion, negative yaw vector
		send_pose('{0, 0, 0, 0, 0, 0}, 0);
		send_pose('{32'sh7fffffff, 32'sh80000000, 16'sh7fff, 16'sh8000, 16'sh7fff,
			16'sh8000}, 0);
		send_pose('{32'sh80000000, 32'sh7fffffff, 16'sh8000, 16'sh8000, 16'sh8000,
			16'sh8000}, 1);
		send_pose('{100, -100, 0, 0, 16'sh4000, 0}, 0);
		send_pose('{65636, -100, 0, 0, 0, 16'sh4000}, 2);
		send_pose('{65637, 200, 16'sh4000, 0, 0, 0}, 0);
		send_pose('{32'sh00010000, 32'sh00020000, 0, 16'sh4000, 0, 0}, 0);
		send_pose('{32'sh00010000, 32'sh00020000, 0, 0, 16'sh2d41, 16'shd2bf}, 0);
		for (int i = 0; i < 6; i++)
			send_pose('{i * 1000, i * 2000, 16'sh1000, 16'sh2000, 16'sh3000, 16'sh0800}, 0);
		send_pose('{32'sh00500000, 0, 0, 0, 0, 16'sh4000}, 0);
		send_pose('{32'shfff00000, 32'sh00400000, 0, 0, 16'shc000, 16'sh4000}, 0);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin write_reg(3'(4 * REG_JUMP_THRESHOLD), 0); write_reg(3'(4 * REG_CALIB_WINDOW), 0); end
				1: begin write_reg(3'(4 * REG_JUMP_THRESHOLD), 32'h7fffffff); write_reg(3'(4 * REG_CALIB_WINDOW), 255); end
				2: begin write_reg(3'(4 * REG_JUMP_THRESHOLD), 32'h00008000); write_reg(3'(4 * REG_CALIB_WINDOW), 3); end
				3: begin write_reg(3'(4 * REG_JUMP_THRESHOLD), 32'hffffffff); write_reg(3'(4 * REG_CALIB_WINDOW), 32'h1ff); end
				4: begin write_reg(3'(4 * REG_JUMP_THRESHOLD), $urandom); write_reg(3'(4 * REG_CALIB_WINDOW), $urandom_range(0, 255)); end
				default: begin write_reg(3'(4 * REG_JUMP_THRESHOLD), 65536); write_reg(3'(4 * REG_CALIB_WINDOW), 10); end
			endcase
			rx_busy = phase != 2;
			gap_max = phase == 3 ? 0 : 17;
			last = '{$urandom, $urandom, 0, 0, 0, 0};
			for (int i = 0; i < 150; i++) begin
				case ($urandom_range(0, 9))
					0: p = '{$urandom, $urandom, rand_q(), rand_q(), rand_q(), rand_q()};
					1: p = near_pose(last, 32'h00040000);
					default: p = near_pose(last, 32'h00008000);
				endcase
				send_pose(p, $urandom_range(0, gap_max));
				last = p;
				if (i == 75 && phase == 1)
					drain();
			end
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
